>>> rtl/dlpg_pkg.sv
package dlpg_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 16;

	localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
	localparam int DVD_W = COORD_BITS + FRAC_BITS + 2;
	localparam int DVS_W = COORD_BITS + 1;
	localparam int QUO_W = FRAC_BITS + 1;
	localparam int CNT_W = $clog2(QUO_W + 1);

	localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIRST
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> rtl/dlpg_div.sv
module dlpg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dlpg_pkg::DVD_W-1:0]  dividend,
	input  logic [dlpg_pkg::DVS_W-1:0]  divisor,
	output logic [dlpg_pkg::QUO_W-1:0]  quotient,
	output dlpg_pkg::div_status_t       status
);

	logic [dlpg_pkg::DVS_W-1:0] rem_q;
	logic [dlpg_pkg::QUO_W-1:0] dq_q;
	logic [dlpg_pkg::DVS_W-1:0] dvs_q;
	logic [dlpg_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [dlpg_pkg::DVS_W:0]   shifted;
	logic [dlpg_pkg::DVS_W:0]   trial;
	logic                       fits;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, dq_q[dlpg_pkg::QUO_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = !trial[dlpg_pkg::DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= dlpg_pkg::CNT_W'(dlpg_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dlpg_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[dlpg_pkg::DVD_W-1:dlpg_pkg::QUO_W];
			dq_q  <= dividend[dlpg_pkg::QUO_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[dlpg_pkg::DVS_W-1:0] : shifted[dlpg_pkg::DVS_W-1:0];
			dq_q  <= {dq_q[dlpg_pkg::QUO_W-2:0], fits};
		end
	end

	assign quotient    = dq_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> rtl/dlpg_round.sv
module dlpg_round (
	input  logic signed [dlpg_pkg::ACC_W-1:0]      acc,
	output logic        [dlpg_pkg::COORD_BITS-1:0] coord
);

	logic [dlpg_pkg::ACC_W:0]        biased;
	logic [dlpg_pkg::COORD_BITS:0]   whole;

	// half up, then clamp to the coordinate range
	assign biased = {acc[dlpg_pkg::ACC_W-1], acc}
		+ ((dlpg_pkg::ACC_W + 1)'(1) << (dlpg_pkg::FRAC_BITS - 1));
	assign whole  = biased[dlpg_pkg::ACC_W-1:dlpg_pkg::FRAC_BITS];

	always_comb begin
		if (biased[dlpg_pkg::ACC_W])
			coord = '0;
		else if (whole[dlpg_pkg::COORD_BITS])
			coord = '1;
		else
			coord = whole[dlpg_pkg::COORD_BITS-1:0];
	end

endmodule

>>> rtl/dda_line_point_generator_top.sv
// DDA line point generator. A start beat (tuser = 0) loads two endpoints; the
// block picks the major axis, orders the endpoints, computes the minor-axis
// increment with a restoring divider that retires one quotient bit per cycle,
// and then emits the first point. A start beat therefore holds off the input
// until that first point is emitted, and the divide is skipped when the major
// delta is zero. Each step beat (tuser = 1) yields the next point, so a line
// streams out at one point per cycle while m_tready is high; tlast marks the
// final point. Step beats with no line in progress are consumed with no output.
module dda_line_point_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// start_x, start_y, end_x, end_y
	input  logic [dlpg_pkg::IN_TDATA_W-1:0]   s_tdata,
	// kind
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// point_x, point_y, zero pad
	output logic [dlpg_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);

	localparam int CB = dlpg_pkg::COORD_BITS;
	localparam int FB = dlpg_pkg::FRAC_BITS;

	dlpg_pkg::state_t state_q, state_d;

	logic [CB-1:0]                    major_pos_q;
	logic [CB-1:0]                    major_end_q;
	logic signed [dlpg_pkg::ACC_W-1:0] minor_acc_q;
	logic signed [dlpg_pkg::ACC_W-1:0] minor_step_q;
	logic                             y_is_major_q;
	logic                             line_active_q;
	logic                             neg_q;

	logic                             out_valid_q;
	logic [2*CB-1:0]                  out_xy_q;
	logic                             out_last_q;

	logic                             accept;
	logic                             out_free;
	logic                             emit;
	logic                             div_start;

	logic [CB-1:0] sx, sy, ex, ey;
	logic [CB:0]   dx, dy;
	logic [CB-1:0] adx, ady;
	logic          y_maj;
	logic [CB-1:0] maj0, maj1, min0, min1, ma0, ma1, mi0, mi1;
	logic [CB-1:0] dmaj;
	logic [CB:0]   dmin;
	logic [CB-1:0] admin;
	logic          dmaj_zero;
	logic [dlpg_pkg::DVD_W-1:0] dividend;
	logic [dlpg_pkg::DVS_W-1:0] divisor;

	logic [dlpg_pkg::QUO_W-1:0] quotient;
	dlpg_pkg::div_status_t      div_st;
	logic [CB-1:0]              minor_coord;
	logic                       is_last;

	// endpoint setup
	assign sx = s_tdata[CB-1:0];
	assign sy = s_tdata[2*CB-1:CB];
	assign ex = s_tdata[3*CB-1:2*CB];
	assign ey = s_tdata[4*CB-1:3*CB];

	assign dx  = {1'b0, ex} - {1'b0, sx};
	assign dy  = {1'b0, ey} - {1'b0, sy};
	assign adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
	assign ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
	assign y_maj = ady > adx;

	assign ma0 = y_maj ? sy : sx;
	assign ma1 = y_maj ? ey : ex;
	assign mi0 = y_maj ? sx : sy;
	assign mi1 = y_maj ? ex : ey;

	always_comb begin
		if (ma0 > ma1) begin
			maj0 = ma1;
			maj1 = ma0;
			min0 = mi1;
			min1 = mi0;
		end else begin
			maj0 = ma0;
			maj1 = ma1;
			min0 = mi0;
			min1 = mi1;
		end
	end

	assign dmaj      = maj1 - maj0;
	assign dmin      = {1'b0, min1} - {1'b0, min0};
	assign admin     = dmin[CB] ? CB'(-dmin) : dmin[CB-1:0];
	assign dmaj_zero = (dmaj == '0);
	assign dividend  = {1'b0, admin, {FB{1'b0}}, 1'b0}
		+ dlpg_pkg::DVD_W'(dmaj);
	assign divisor   = {dmaj, 1'b0};

	dlpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.status   (div_st)
	);

	dlpg_round u_round (
		.acc   (minor_acc_q),
		.coord (minor_coord)
	);

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_last  = (major_pos_q == major_end_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlpg_pkg::ST_IDLE: begin
				if (accept && s_tuser == dlpg_pkg::KIND_START)
					state_d = dmaj_zero ? dlpg_pkg::ST_FIRST : dlpg_pkg::ST_DIV;
			end
			dlpg_pkg::ST_DIV: begin
				if (div_st.done)
					state_d = dlpg_pkg::ST_FIRST;
			end
			dlpg_pkg::ST_FIRST: begin
				if (out_free)
					state_d = dlpg_pkg::ST_IDLE;
			end
			default: state_d = dlpg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			dlpg_pkg::ST_IDLE: begin
				s_tready  = out_free;
				div_start = accept && s_tuser == dlpg_pkg::KIND_START && !dmaj_zero;
				emit      = accept && s_tuser == dlpg_pkg::KIND_STEP && line_active_q;
			end
			dlpg_pkg::ST_DIV: begin
			end
			dlpg_pkg::ST_FIRST: begin
				emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= dlpg_pkg::ST_IDLE;
			line_active_q <= 1'b0;
			major_pos_q   <= '0;
			major_end_q   <= '0;
			minor_acc_q   <= '0;
			minor_step_q  <= '0;
			y_is_major_q  <= 1'b0;
			neg_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (accept && s_tuser == dlpg_pkg::KIND_START) begin
				line_active_q <= 1'b1;
				y_is_major_q  <= y_maj;
				major_pos_q   <= maj0;
				major_end_q   <= maj1;
				minor_acc_q   <= {1'b0, min0, {FB{1'b0}}};
				minor_step_q  <= '0;
				neg_q         <= dmin[CB];
			end else if (state_q == dlpg_pkg::ST_DIV && div_st.done) begin
				minor_step_q <= neg_q ? -dlpg_pkg::ACC_W'(quotient)
					: dlpg_pkg::ACC_W'(quotient);
			end else if (emit) begin
				if (is_last) begin
					line_active_q <= 1'b0;
				end else begin
					major_pos_q <= major_pos_q + 1'b1;
					minor_acc_q <= minor_acc_q + minor_step_q;
				end
			end

			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_xy_q   <= y_is_major_q ? {major_pos_q, minor_coord}
				: {minor_coord, major_pos_q};
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = dlpg_pkg::OUT_TDATA_W'(out_xy_q);
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != dlpg_pkg::ST_IDLE |-> !s_tready)
		else $error("input ready while a line setup is in progress");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == dlpg_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dlpg_pkg::ST_DIV && !div_st.done |-> div_st.busy)
		else $error("divider idle while waiting for the increment");

	a_idle_step_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == dlpg_pkg::KIND_STEP && !line_active_q |=> !m_tvalid)
		else $error("point emitted with no line in progress");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> major_pos_q <= major_end_q)
		else $error("major coordinate ran past the line end");
`endif

endmodule
